// File: sv/ppcfc_pkg.sv
// Package for the per-peer credit flow control block.
// Holds the beat types, the command codes, the state encoding and the control structs.
// No dependencies.
package ppcfc_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned PEER_W  = 4;
  localparam int unsigned CREDIT_W = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_SEND    = 2'd0,
    CMD_MESSAGE = 2'd1,
    CMD_CREDITS = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [PEER_W-1:0]   peer;
    logic [CREDIT_W-1:0] returned_credits;
  } in_t;

  typedef struct packed {
    logic                granted;
    logic [CREDIT_W-1:0] piggyback_credits;
    logic                emit_credit_message;
    logic [CREDIT_W-1:0] credit_message_count;
    logic                overflow;
  } out_t;

  typedef enum logic [1:0] {
    S_CLEAR  = 2'd0,
    S_IDLE   = 2'd1,
    S_READ   = 2'd2,
    S_UPDATE = 2'd3
  } state_t;

  typedef struct packed {
    logic clear_we;
    logic load_item;
    logic rd_en;
    logic upd;
  } ppcfc_cmd_t;

  typedef struct packed {
    logic clear_last;
  } ppcfc_sts_t;

endpackage

// File: sv/ppcfc_ctrl.sv
// Controller for the per-peer credit flow control block.
// Sequences the clearing pass and the read-modify-write of one beat; owns the output valid.
// Depends on ppcfc_pkg.
module ppcfc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  ppcfc_pkg::ppcfc_sts_t sts,
  output ppcfc_pkg::ppcfc_cmd_t cmd
);
  import ppcfc_pkg::*;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.clear_we  = 1'b0;
    cmd.load_item = 1'b0;
    cmd.rd_en     = 1'b0;
    cmd.upd       = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_we = 1'b1;
      end
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
      end
      S_UPDATE: begin
        cmd.upd = slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.upd) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: sv/ppcfc_dp.sv
// Datapath for the per-peer credit flow control block.
// Holds the per-peer credit memory, the beat register, the credit arithmetic and the result register.
// Depends on ppcfc_pkg.
module ppcfc_dp #(
  parameter int unsigned PEER_COUNT    = 16,
  parameter int unsigned CREDIT_WINDOW = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ppcfc_pkg::in_t        in_data,
  input  ppcfc_pkg::ppcfc_cmd_t cmd,
  output ppcfc_pkg::ppcfc_sts_t sts,
  output ppcfc_pkg::out_t       out_data
);
  import ppcfc_pkg::*;

  localparam int unsigned AW = (PEER_COUNT > 1) ? $clog2(PEER_COUNT) : 1;
  localparam int unsigned CW = $clog2(CREDIT_WINDOW + 1);
  localparam int unsigned SW = ((CW > CREDIT_W) ? CW : CREDIT_W) + 1;
  localparam logic [CW-1:0] WIN = CW'(CREDIT_WINDOW);

  logic [2*CW-1:0] mem [PEER_COUNT];
  logic [2*CW-1:0] rd_data;
  logic [AW-1:0]   clr_addr;
  in_t             item;

  logic [AW-1:0]   addr;
  logic            peer_ok;
  logic [CW-1:0]   avail;
  logic [CW-1:0]   owed;
  logic [SW-1:0]   sum;
  logic            sat;
  logic [CW-1:0]   avail_add;
  logic [CW-1:0]   owed_inc;
  logic            owed_full;
  logic [CW-1:0]   avail_new;
  logic [CW-1:0]   owed_new;
  out_t            res;
  logic            mem_we;
  logic [AW-1:0]   wr_addr;
  logic [2*CW-1:0] wr_data;

  assign sts.clear_last = (clr_addr == AW'(PEER_COUNT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_we && !sts.clear_last) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_data;
    end
  end

  assign addr    = AW'(item.peer);
  assign peer_ok = (32'(item.peer) < PEER_COUNT);
  assign avail   = rd_data[2*CW-1:CW];
  assign owed    = rd_data[CW-1:0];

  assign sum       = SW'(avail) + SW'(item.returned_credits);
  assign sat       = (sum > SW'(CREDIT_WINDOW));
  assign avail_add = sat ? WIN : CW'(sum);
  assign owed_inc  = CW'(owed + CW'(1));
  assign owed_full = (owed_inc >= WIN);

  always_comb begin
    avail_new = avail;
    owed_new  = owed;
    res       = '0;
    if (peer_ok) begin
      unique case (cmd_e'(item.cmd))
        CMD_SEND: begin
          if (avail != '0) begin
            avail_new             = avail - CW'(1);
            owed_new              = '0;
            res.granted           = 1'b1;
            res.piggyback_credits = CREDIT_W'(owed);
          end
        end
        CMD_MESSAGE: begin
          avail_new    = avail_add;
          res.overflow = sat;
          if (owed_full) begin
            owed_new                 = '0;
            res.emit_credit_message  = 1'b1;
            res.credit_message_count = CREDIT_W'(CREDIT_WINDOW);
          end else begin
            owed_new = owed_inc;
          end
        end
        CMD_CREDITS: begin
          avail_new    = avail_add;
          res.overflow = sat;
        end
        CMD_NONE: begin
          res = '0;
        end
        default: begin
          res = '0;
        end
      endcase
    end
  end

  assign mem_we  = cmd.clear_we || (cmd.upd && peer_ok);
  assign wr_addr = cmd.clear_we ? clr_addr : addr;
  assign wr_data = cmd.clear_we ? {WIN, CW'(0)} : {avail_new, owed_new};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      out_data <= res;
    end
  end

endmodule

// File: sv/per_peer_credit_flow_control.sv
// Per-peer credit flow control: top level joining the controller and the datapath.
// Each beat passes through the accept, read and update states into the result register;
// the update waits while the output holds a beat not yet taken. No new beat is accepted
// until the read-modify-write of the credit memory (accept, read, update) is done.
// Reset: a clearing pass over every peer address loads every peer with a full window
// and no owed credits; in_ready stays low until it ends.
module per_peer_credit_flow_control #(
  parameter int unsigned PEER_COUNT    = 16,
  parameter int unsigned CREDIT_WINDOW = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ppcfc_pkg::in_t     in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ppcfc_pkg::out_t    out_data
);
  import ppcfc_pkg::*;

  ppcfc_cmd_t cmd;
  ppcfc_sts_t sts;

  ppcfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ppcfc_dp #(
    .PEER_COUNT    (PEER_COUNT),
    .CREDIT_WINDOW (CREDIT_WINDOW)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  // The clearing pass always follows reset, so no beat is taken right after it.
  a_clear_after_reset: assert property (@(posedge clk) $past(rst) |-> !in_ready)
    else $error("input accepted during the clearing pass");

  // Only one beat is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second beat accepted while one is in flight");

  // Piggybacked credits only travel on a granted send.
  a_piggyback_grant: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.piggyback_credits != '0) |-> out_data.granted)
    else $error("piggyback credits without a grant");

  // A memory write never coincides with an accepted beat.
  a_no_wr_on_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> !(cmd.upd || cmd.clear_we))
    else $error("memory update overlaps an accepted beat");

endmodule
